FILE: src/wave_memory_channel_counter_macros.svh
// Assertion macros shared by the checker of the wave memory channel counter.
`ifndef WAVE_MEMORY_CHANNEL_COUNTER_MACROS_SVH
`define WAVE_MEMORY_CHANNEL_COUNTER_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define WMCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define WMCC_ASSERT_IMP(label, ante, cons, msg) \
    `WMCC_ASSERT(label, (ante) |-> (cons), msg)

// Implication checked in the next cycle.
`define WMCC_ASSERT_NEXT(label, ante, cons, msg) \
    `WMCC_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: src/wmcc_pkg.sv
// Package of shared types and constants for the wave memory channel counter.
package wmcc_pkg;

    localparam int RAM_ADDR_BITS_DEFAULT = 14;
    localparam int SEGMENT_BITS_DEFAULT  = 7;

    localparam int OPCODE_W  = 3;
    localparam int DATA_W    = 8;
    localparam int SEGMENT_W = 7;
    localparam int SHIFT_W   = 6;
    localparam int SAMPLE_W  = DATA_W + SHIFT_W;

    localparam logic [OPCODE_W-1:0] OP_WRITE    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READ     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_ON  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD_OFF = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RUN_ON   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RUN_OFF  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_VOLUME   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd7;

    // Access strobes for the wave store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } wmcc_store_req_t;

endpackage

FILE: src/wave_memory_channel_counter.sv
// Top level of the sampler channel wave memory with its address counter.
//
// Usage: one request enters on req_valid/req_ready with opcode, data_in and
// segment; it is taken at a clock edge where both are high. Every request
// gives exactly one response on rsp_valid/rsp_ready, carrying read_data,
// sample_out and the status bits end_of_sound_n, zero_cross, running and
// loading as they stand after that request.
// An accepted request passes the synchronous store read, then the response
// register, before rsp_valid. Throughput is one request per cycle while the
// receiver does not stall; the counter and flags are updated in the cycle a
// request is accepted, so the next request sees them at once, and a host
// write lands in the store before any later read can address it.
// When the receiver stalls, the response register holds and the request in
// the store stage waits; req_ready drops only when both are occupied.
// Reset clears the counter, flags, volume latch and pipeline valid bits;
// the store contents are undefined until written and need no clearing.
module wave_memory_channel_counter #(
    parameter int RAM_ADDR_BITS = wmcc_pkg::RAM_ADDR_BITS_DEFAULT,
    parameter int SEGMENT_BITS  = wmcc_pkg::SEGMENT_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [wmcc_pkg::OPCODE_W-1:0]   opcode,
    input  logic [wmcc_pkg::DATA_W-1:0]     data_in,
    input  logic [wmcc_pkg::SEGMENT_W-1:0]  segment,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [wmcc_pkg::DATA_W-1:0]     read_data,
    output logic [wmcc_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                            end_of_sound_n,
    output logic                            zero_cross,
    output logic                            running,
    output logic                            loading
);
    import wmcc_pkg::*;

    // The counter is one bit wider than the store address; its top bit is
    // the end-of-sound flag.
    localparam int CNT_W = RAM_ADDR_BITS + 1;
    localparam int SEG_NUM_BITS = RAM_ADDR_BITS - SEGMENT_BITS;
    localparam logic [CNT_W-1:0] SEG_NUM_MASK = CNT_W'((64'd1 << SEG_NUM_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] STORE_BASE = CNT_W'(64'd1 << RAM_ADDR_BITS);

    // Architectural state.
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              fresh_reg, fresh_next;
    logic              load_reg, load_next;
    logic              run_reg, run_next;
    logic [DATA_W-1:0] vol_reg, vol_next;

    // Store stage: the request whose read is in flight.
    logic s1_valid_reg;
    logic s1_rd_reg;
    logic s1_play_reg;
    logic s1_eos_reg;
    logic s1_zc_reg;
    logic s1_run_reg;
    logic s1_load_reg;

    // Response register.
    logic                rsp_valid_reg;
    logic [DATA_W-1:0]   rd_data_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                eos_reg;
    logic                zc_reg;
    logic                run_out_reg;
    logic                load_out_reg;

    logic              accept;
    logic              s1_move;
    logic              read_hit;
    logic              play;
    logic [CNT_W-1:0]  seg_start;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_seg_inc;
    logic [DATA_W-1:0] store_rdata;
    wmcc_store_req_t   store_req;

    // The store stage moves on when the response register is free or
    // being emptied in this cycle.
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_move;
    assign accept    = req_valid && req_ready;

    // A read right after an address load returns zero without touching
    // the store; a tick only plays while running with a nonzero volume.
    assign read_hit = (opcode == OP_READ) && !fresh_reg;
    assign play     = (opcode == OP_TICK) && run_reg && (vol_reg != '0);

    assign seg_start   = STORE_BASE | ((CNT_W'(segment) & SEG_NUM_MASK) << SEGMENT_BITS);
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign cnt_seg_inc = {cnt_reg[CNT_W-1:SEGMENT_BITS], cnt_inc[SEGMENT_BITS-1:0]};

    always_comb
    begin
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        load_next  = load_reg;
        run_next   = run_reg;
        vol_next   = vol_reg;
        case (opcode)
            OP_WRITE:
            begin
                fresh_next = 1'b0;
                cnt_next   = cnt_inc;
            end
            OP_READ:
            begin
                fresh_next = 1'b0;
                if (!fresh_reg)
                begin
                    cnt_next = cnt_inc;
                end
            end
            OP_LOAD_ON:
            begin
                load_next  = 1'b1;
                cnt_next   = seg_start;
                fresh_next = 1'b1;
            end
            OP_LOAD_OFF:
            begin
                load_next = 1'b0;
            end
            OP_RUN_ON:
            begin
                run_next = 1'b1;
                if (!load_reg)
                begin
                    cnt_next   = seg_start;
                    fresh_next = 1'b1;
                end
            end
            OP_RUN_OFF:
            begin
                run_next = 1'b0;
            end
            OP_VOLUME:
            begin
                vol_next = data_in;
            end
            OP_TICK:
            begin
                // In load mode the counter runs over its full width; in run
                // mode it loops inside the current segment.
                if (play)
                begin
                    cnt_next = load_reg ? cnt_inc : cnt_seg_inc;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign store_req.wr_en = accept && (opcode == OP_WRITE);
    assign store_req.rd_en = accept && (read_hit || play);

    wmcc_store #(
        .ADDR_BITS (RAM_ADDR_BITS)
    ) u_store (
        .clk   (clk),
        .req   (store_req),
        .addr  (cnt_reg[RAM_ADDR_BITS-1:0]),
        .wdata (data_in),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            fresh_reg <= 1'b0;
            load_reg  <= 1'b0;
            run_reg   <= 1'b0;
            vol_reg   <= '0;
        end
        else if (accept)
        begin
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            load_reg  <= load_next;
            run_reg   <= run_next;
            vol_reg   <= vol_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    // Status bits are those after the request, so they are captured here.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg   <= read_hit;
            s1_play_reg <= play;
            s1_eos_reg  <= cnt_next[RAM_ADDR_BITS];
            s1_zc_reg   <= cnt_next[SEGMENT_BITS-1];
            s1_run_reg  <= run_next;
            s1_load_reg <= load_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            rd_data_reg  <= s1_rd_reg ? store_rdata : '0;
            sample_reg   <= s1_play_reg ? {store_rdata, SHIFT_W'(0)} : '0;
            eos_reg      <= s1_eos_reg;
            zc_reg       <= s1_zc_reg;
            run_out_reg  <= s1_run_reg;
            load_out_reg <= s1_load_reg;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign read_data      = rd_data_reg;
    assign sample_out     = sample_reg;
    assign end_of_sound_n = eos_reg;
    assign zero_cross     = zc_reg;
    assign running        = run_out_reg;
    assign loading        = load_out_reg;

endmodule

FILE: src/wmcc_store.sv
// Single-port wave store with a registered read port.
module wmcc_store #(
    parameter int ADDR_BITS = wmcc_pkg::RAM_ADDR_BITS_DEFAULT
) (
    input  logic                          clk,
    input  wmcc_pkg::wmcc_store_req_t     req,
    input  logic [ADDR_BITS-1:0]          addr,
    input  logic [wmcc_pkg::DATA_W-1:0]   wdata,
    output logic [wmcc_pkg::DATA_W-1:0]   rdata
);
    import wmcc_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/wmcc_checker.sv
// Port-level checker for the wave memory channel counter and its bind.
`include "wave_memory_channel_counter_macros.svh"

module wmcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [wmcc_pkg::DATA_W-1:0]   read_data,
    input logic [wmcc_pkg::SAMPLE_W-1:0] sample_out,
    input logic                          running
);
    import wmcc_pkg::*;

    // A stalled response must stay offered.
    `WMCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // Played samples are whole bytes moved up six places.
    `WMCC_ASSERT_IMP(a_sample_align, rsp_valid, sample_out[SHIFT_W-1:0] == '0, "sample has low bits set")

    // Only a running channel can play a sample.
    `WMCC_ASSERT_IMP(a_sample_running, rsp_valid && (sample_out != '0), running, "sample while not running")

    // A host read and a played sample never share one response.
    `WMCC_ASSERT_IMP(a_read_or_sample, rsp_valid && (read_data != '0), sample_out == '0, "read and sample together")

endmodule

bind wave_memory_channel_counter wmcc_checker u_wmcc_checker (.*);
